[rtl/ipd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the +IPD frame deframer.
// No dependencies; every other file of the block imports this package.
package ipd_pkg;

  // Field widths of the channels.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LINK_W    = 3;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  // Default request copy limit in payload bytes.
  localparam int unsigned KEEP_LIMIT = 767;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGHEST_LINK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONGEST_LEN  = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [LINK_W-1:0] HIGHEST_LINK_RST = LINK_W'(4);
  localparam logic [LEN_W-1:0]  LONGEST_LEN_RST  = LEN_W'(2047);

  // Header characters.
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // The marker is five characters long; the match position counts 0 to 4.
  localparam int unsigned MARKER_LEN = 5;
  localparam int unsigned MATCH_W    = 3;

  // Saturation limits of the two header numbers.
  localparam logic [ID_W-1:0]  ID_SAT  = '1;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  typedef struct packed {
    logic [LINK_W-1:0] highest_link_id;
    logic [LEN_W-1:0]  longest_payload;
  } ipd_cfg_t;

  typedef struct packed {
    logic [LINK_W-1:0] link_id;
    logic [BYTE_W-1:0] data_byte;
    logic              keep;
    logic              last;
  } ipd_result_t;

  typedef struct packed {
    logic byte_pending;
    logic in_frame;
  } ipd_status_t;

  // Expected character at a given position of the "+IPD," marker.
  function automatic logic [BYTE_W-1:0] marker_char(input logic [MATCH_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    case (pos)
      MATCH_W'(0): ch = CH_PLUS;
      MATCH_W'(1): ch = CH_I;
      MATCH_W'(2): ch = CH_P;
      MATCH_W'(3): ch = CH_D;
      default:     ch = CH_COMMA;
    endcase
    return ch;
  endfunction

endpackage

[rtl/ipd_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the deframer: received bytes,
// payload results and configuration writes. Depends on ipd_pkg.
interface ipd_rx_if;
  import ipd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_res_if;
  import ipd_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] link_id;
  logic [BYTE_W-1:0] data_byte;
  logic              keep;
  logic              last;
  modport source (output valid, output link_id, output data_byte, output keep,
                  output last, input ready);
  modport sink   (input valid, input link_id, input data_byte, input keep,
                  input last, output ready);
endinterface

interface ipd_cfg_if;
  import ipd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ipd_frame_deframer_core.sv]
`timescale 1ns / 1ps
// +IPD frame deframer: one received byte per item in, one payload item out per payload byte.
// Path: an accepted payload byte passes the parser's input register and then the result register.
// Throughput: one byte per cycle while the result side does not stall payload bytes.
// Reset: rst_ni clears the parser to marker hunting, empties both stages and
// loads the registers with link limit 4 and length limit 2047.
// Depends on ipd_pkg, the channel interfaces, ipd_cfg_regs, ipd_parser, ipd_out_stage.
module ipd_frame_deframer_core #(
  parameter int unsigned KeepLimit = ipd_pkg::KEEP_LIMIT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipd_rx_if.sink    rx_if,
  ipd_res_if.source res_if,
  ipd_cfg_if.sink   cfg_if
);
  import ipd_pkg::*;

  ipd_cfg_t    cfg;
  ipd_result_t res_data;
  ipd_status_t status;
  logic        res_valid;
  logic        res_ready;
  logic        res_fire;

  // Register file; writes are registered and always accepted.
  ipd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // The parser holds each accepted byte in its input register,
  // updates the header state from it and, inside a frame, offers a result.
  // Bytes outside a frame never wait on the result side.
  ipd_parser #(
    .KeepLimit (KeepLimit)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (rx_if.valid),
    .byte_ready_o (rx_if.ready),
    .byte_i       (rx_if.rx_byte),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res_data),
    .status_o     (status)
  );

  // The result register decouples the consumer; while it waits, the parser's
  // input register can still take the next byte if it is empty.
  ipd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_data_i  (res_data),
    .res_if     (res_if)
  );

  assign res_fire = res_valid && res_ready;

  // The final payload byte of a frame returns the parser to marker hunting.
  a_last_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_data.last |=> !status.in_frame)
    else $error("parser still in frame after last payload byte");

  // Any other payload byte keeps the parser inside the frame.
  a_mid_keeps_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && !res_data.last |=> status.in_frame)
    else $error("parser left frame before last payload byte");

  // The byte channel only stalls while a byte is held in the input register.
  a_stall_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_if.ready |-> status.byte_pending)
    else $error("byte channel stalled with empty input register");

endmodule

[rtl/ipd_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the deframer.
// Depends on ipd_pkg and ipd_cfg_if.
module ipd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  ipd_cfg_if.sink           cfg_if,
  output ipd_pkg::ipd_cfg_t cfg_o
);
  import ipd_pkg::*;

  logic [LINK_W-1:0] highest_q;
  logic [LEN_W-1:0]  longest_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= HIGHEST_LINK_RST;
      longest_q <= LONGEST_LEN_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_IDX_HIGHEST_LINK: highest_q <= cfg_if.data[LINK_W-1:0];
        CFG_IDX_LONGEST_LEN:  longest_q <= cfg_if.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.highest_link_id = highest_q;
  assign cfg_o.longest_payload = longest_q;

endmodule

[rtl/ipd_parser.sv]
`timescale 1ns / 1ps
// Input byte register and header/payload state machine of the deframer.
// Depends on ipd_pkg.
module ipd_parser #(
  parameter int unsigned KeepLimit = ipd_pkg::KEEP_LIMIT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipd_pkg::ipd_cfg_t             cfg_i,
  input  logic                          byte_valid_i,
  output logic                          byte_ready_o,
  input  logic [ipd_pkg::BYTE_W-1:0]    byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ipd_pkg::ipd_result_t          res_o,
  output ipd_pkg::ipd_status_t          status_o
);
  import ipd_pkg::*;

  // The position counter only has to tell whether it is still below the limit.
  localparam int unsigned     PosW   = $clog2(KeepLimit + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(KeepLimit);
  localparam int unsigned     IdMulW  = ID_W + 4;
  localparam int unsigned     LenMulW = LEN_W + 4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_DATA
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               ended_q, ended_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [LINK_W-1:0]  link_q, link_d;
  logic               pend_q, pend_d;
  logic [BYTE_W-1:0]  byte_q;

  logic               advance;
  logic               is_digit;
  logic [3:0]         digit;
  logic [IdMulW-1:0]  id_ext, id_next;
  logic [LenMulW-1:0] len_ext, len_next;
  logic               reject;

  // A held byte moves on unless it is a payload byte and the result side is full.
  assign advance      = pend_q && ((phase_q != PH_DATA) || res_ready_i);
  assign byte_ready_o = !pend_q || advance;

  always_comb begin
    if (byte_valid_i && byte_ready_o) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i && byte_ready_o) begin
      byte_q <= byte_i;
    end
  end

  // Decimal accumulation: times ten as two shifts and an add.
  assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign digit    = byte_q[3:0];
  assign id_ext   = IdMulW'(id_q);
  assign id_next  = (id_ext << 3) + (id_ext << 1) + IdMulW'(digit);
  assign len_ext  = LenMulW'(len_q);
  assign len_next = (len_ext << 3) + (len_ext << 1) + LenMulW'(digit);

  assign reject = (id_q > ID_W'(cfg_i.highest_link_id)) || (len_q == '0) ||
                  (len_q > cfg_i.longest_payload);

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    id_d    = id_q;
    len_d   = len_q;
    ended_d = ended_q;
    left_d  = left_q;
    pos_d   = pos_q;
    link_d  = link_q;
    if (advance) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_q == marker_char(match_q)) begin
            if (match_q == MATCH_W'(MARKER_LEN - 1)) begin
              match_d = '0;
              phase_d = PH_ID;
              id_d    = '0;
              ended_d = 1'b0;
            end else begin
              match_d = match_q + MATCH_W'(1);
            end
          end else begin
            match_d = (byte_q == CH_PLUS) ? MATCH_W'(1) : '0;
          end
        end
        PH_ID: begin
          if (byte_q == CH_COMMA) begin
            phase_d = PH_LEN;
            len_d   = '0;
            ended_d = 1'b0;
          end else if (is_digit && !ended_q) begin
            id_d = (id_next > IdMulW'(ID_SAT)) ? ID_SAT : id_next[ID_W-1:0];
          end else begin
            ended_d = 1'b1;
          end
        end
        PH_LEN: begin
          if (byte_q == CH_COLON) begin
            match_d = '0;
            if (reject) begin
              phase_d = PH_HUNT;
            end else begin
              phase_d = PH_DATA;
              link_d  = id_q[LINK_W-1:0];
              left_d  = len_q;
              pos_d   = '0;
            end
          end else if (is_digit && !ended_q) begin
            len_d = (len_next > LenMulW'(LEN_SAT)) ? LEN_SAT : len_next[LEN_W-1:0];
          end else begin
            ended_d = 1'b1;
          end
        end
        PH_DATA: begin
          if (pos_q != PosMax) begin
            pos_d = pos_q + PosW'(1);
          end
          if (left_q != '0) begin
            left_d = left_q - LEN_W'(1);
          end
          if (left_q <= LEN_W'(1)) begin
            phase_d = PH_HUNT;
            match_d = '0;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      match_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      ended_q <= 1'b0;
      left_q  <= '0;
      pos_q   <= '0;
      link_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      id_q    <= id_d;
      len_q   <= len_d;
      ended_q <= ended_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      link_q  <= link_d;
      pend_q  <= pend_d;
    end
  end

  assign res_valid_o     = pend_q && (phase_q == PH_DATA);
  assign res_o.link_id   = link_q;
  assign res_o.data_byte = byte_q;
  assign res_o.keep      = (pos_q < PosMax);
  assign res_o.last      = (left_q <= LEN_W'(1));

  assign status_o.byte_pending = pend_q;
  assign status_o.in_frame     = (phase_q == PH_DATA);

endmodule

[rtl/ipd_out_stage.sv]
`timescale 1ns / 1ps
// Result register between the parser and the result channel.
// Depends on ipd_pkg and ipd_res_if.
module ipd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ipd_pkg::ipd_result_t in_data_i,
  ipd_res_if.source            res_if
);
  import ipd_pkg::*;

  logic        valid_q;
  ipd_result_t data_q;

  assign in_ready_o = !valid_q || res_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign res_if.valid     = valid_q;
  assign res_if.link_id   = data_q.link_id;
  assign res_if.data_byte = data_q.data_byte;
  assign res_if.keep      = data_q.keep;
  assign res_if.last      = data_q.last;

endmodule
